// File: sv/can_signal_frame_packer_macros.svh
// Assertion macros shared by the frame packer RTL.
// Relies on a clock named clock and a synchronous active-high reset named reset.
`ifndef CAN_SIGNAL_FRAME_PACKER_MACROS_SVH
`define CAN_SIGNAL_FRAME_PACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSFP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame packer check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define CSFP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame packer check failed: next-cycle implication");

`endif

// File: sv/csfp_pkg.sv
// Types, codes and the DLC length table for the CAN signal frame packer.
// No dependencies.
package csfp_pkg;

   // Byte pointer wide enough to step past the end of the largest payload.
   typedef logic [6:0] ptr_type;

   // One access slot on the payload store: read port and write port.
   typedef struct packed {
      logic       rd_en;
      ptr_type    rd_ptr;
      logic       wr_en;
      ptr_type    wr_ptr;
      logic [7:0] wr_data;
   } mem_req_type;

   localparam logic       REQ_WRITE     = 1'b0;
   localparam logic       REQ_SEND      = 1'b1;
   localparam logic [1:0] KIND_UNSIGNED = 2'd0;
   localparam logic [1:0] KIND_SIGNED   = 2'd1;
   localparam logic [1:0] KIND_RAW      = 2'd2;
   localparam logic       ORDER_INTEL   = 1'b1;
   localparam logic [6:0] FIELD_MAX_LEN = 7'd64;

   // CAN FD data length code to byte count.
   function automatic logic [6:0] dlc_len(input logic [3:0] dlc);
      logic [6:0] n;
      case (dlc)
         4'd9:    n = 7'd12;
         4'd10:   n = 7'd16;
         4'd11:   n = 7'd20;
         4'd12:   n = 7'd24;
         4'd13:   n = 7'd32;
         4'd14:   n = 7'd48;
         4'd15:   n = 7'd64;
         default: n = {3'b000, dlc};
      endcase
      return n;
   endfunction

endpackage

// File: sv/csfp_cond.sv
// Value conditioning: saturate unsigned or signed values to the field width; raw values pass through.
// Depends on csfp_pkg for the value kind codes.
module csfp_cond (
   input  logic [63:0] raw_value,
   input  logic [1:0]  value_kind,
   input  logic [6:0]  sig_len,
   output logic [63:0] cond_value,
   output logic [63:0] len_mask
);

   logic        neg;
   logic        full;
   logic [6:0]  len_m1;
   logic [63:0] hi_mask;
   logic [63:0] sgn_val;
   logic [63:0] uns_val;

   always_comb begin
      neg     = raw_value[63];
      full    = (sig_len >= csfp_pkg::FIELD_MAX_LEN);
      len_m1  = sig_len - 7'd1;
      len_mask = full ? {64{1'b1}} : ((64'd1 << sig_len[5:0]) - 64'd1);
      // Bits from the field's sign position upwards.
      hi_mask = {64{1'b1}} << len_m1[5:0];

      if (full) begin
         sgn_val = raw_value;
      end else if (!neg && ((raw_value & hi_mask) != 64'd0)) begin
         sgn_val = ~hi_mask & len_mask;
      end else if (neg && ((raw_value & hi_mask) != hi_mask)) begin
         sgn_val = hi_mask & len_mask;
      end else begin
         sgn_val = raw_value & len_mask;
      end

      if (neg) begin
         uns_val = 64'd0;
      end else if (!full && ((raw_value & ~len_mask) != 64'd0)) begin
         uns_val = len_mask;
      end else begin
         uns_val = raw_value;
      end

      case (value_kind)
         csfp_pkg::KIND_RAW:    cond_value = raw_value;
         csfp_pkg::KIND_SIGNED: cond_value = sgn_val;
         default:               cond_value = uns_val;
      endcase
   end

endmodule

// File: sv/csfp_store.sv
// Payload byte store: synchronous memory with a registered read.
// Depends on csfp_pkg for the access struct; a per-byte valid vector stands in for the clear.
module csfp_store #(
   parameter int PAYLOAD_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  csfp_pkg::mem_req_type mreq,
   output logic [7:0]            rd_data
);

   localparam int AW = $clog2(PAYLOAD_BYTES);

   logic [7:0]               mem [PAYLOAD_BYTES];
   logic [PAYLOAD_BYTES-1:0] vld_ff;
   logic [7:0]               rd_q_ff;
   logic                     rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mreq.wr_en) begin
         mem[mreq.wr_ptr[AW-1:0]] <= mreq.wr_data;
      end
      if (mreq.rd_en) begin
         rd_q_ff   <= mem[mreq.rd_ptr[AW-1:0]];
         rd_vld_ff <= vld_ff[mreq.rd_ptr[AW-1:0]];
      end
   end

   // Bytes never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mreq.wr_en) begin
         vld_ff[mreq.wr_ptr[AW-1:0]] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : 8'd0;

endmodule

// File: sv/can_signal_frame_packer.sv
// CAN / CAN FD signal frame packer: packs conditioned signals into a payload store
// and streams the payload out. Depends on csfp_pkg, csfp_cond, csfp_store, macros header.
//
//   channel | direction | handshake              | carries
//   req_    | in        | req_valid / req_stall  | write or send transaction
//   rsp_    | out       | rsp_valid / rsp_stall  | one payload byte per transaction
//   csr_    | in        | csr_valid / csr_ready  | len_code (data length code)
//
// A write transaction steps through accept, condition, align, one read-modify-write per touched
// payload byte (1 to 9) and a final write-back.
// Emission reads each byte from the store and then loads it into the output register while
// rsp_stall is low; a stall holds the output register and the sequencer waits on it.
// Reset is synchronous: control state clears, len_code goes to 8 and every stored byte is
// invalidated at once, so no clearing pass is needed.
`include "can_signal_frame_packer_macros.svh"

module can_signal_frame_packer #(
   parameter int PAYLOAD_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] req_raw_value,
   input  logic [1:0]  req_value_kind,
   input  logic [8:0]  req_first_bit,
   input  logic [6:0]  req_sig_len,
   input  logic        req_endian,
   input  logic        req_send_after,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic [5:0]  rsp_byte_index,
   output logic        rsp_last,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_len_code
);

   localparam logic [6:0] PB = 7'(PAYLOAD_BYTES);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_COND    = 3'd1;
   localparam logic [2:0] ST_ALIGN   = 3'd2;
   localparam logic [2:0] ST_RMW     = 3'd3;
   localparam logic [2:0] ST_DRAIN   = 3'd4;
   localparam logic [2:0] ST_EMIT_RD = 3'd5;
   localparam logic [2:0] ST_EMIT_LD = 3'd6;

   // control state
   logic [2:0]  state_ff, state_in;
   logic [3:0]  dlc_ff, dlc_in;
   logic        pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   // transaction fields
   logic        typ_ff, typ_in;
   logic [63:0] raw_ff, raw_in;
   logic [1:0]  kind_ff, kind_in;
   logic [8:0]  start_ff, start_in;
   logic [6:0]  len_ff, len_in;
   logic        order_ff, order_in;
   logic        send_ff, send_in;
   // datapath
   logic [63:0] val_ff, val_in;
   logic [71:0] dat_ff, dat_in;
   logic [71:0] msk_ff, msk_in;
   csfp_pkg::ptr_type ptr_ff, ptr_in;
   csfp_pkg::ptr_type wptr_ff, wptr_in;
   logic [7:0]  wdat_ff, wdat_in;
   logic [7:0]  wmsk_ff, wmsk_in;
   logic [6:0]  emit_n_ff, emit_n_in;
   logic [6:0]  emit_k_ff, emit_k_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [5:0]  rsp_idx_ff, rsp_idx_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [63:0] cond_value;
   logic [63:0] len_mask;
   logic [7:0]  rd_data;
   csfp_pkg::mem_req_type mreq;

   logic        req_acc;
   logic        rsp_take;
   logic        out_free;
   logic [6:0]  frame_n;
   logic [6:0]  top_sh;
   logic [2:0]  mot_sh;
   logic [63:0] mot_val;
   logic [63:0] mot_msk;
   logic [7:0]  cur_dat;
   logic [7:0]  cur_msk;
   logic [71:0] nxt_dat;
   logic [71:0] nxt_msk;

   csfp_cond u_cond (
      .raw_value  (raw_ff),
      .value_kind (kind_ff),
      .sig_len    (len_ff),
      .cond_value (cond_value),
      .len_mask   (len_mask)
   );

   csfp_store #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .mreq    (mreq),
      .rd_data (rd_data)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_index = rsp_idx_ff;
   assign rsp_last       = rsp_last_ff;

   assign req_acc  = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // byte count of the frame, capped at the store size
      frame_n = (csfp_pkg::dlc_len(dlc_ff) > PB) ? PB : csfp_pkg::dlc_len(dlc_ff);

      // Motorola: top-align the field, then drop it so its MSB lands on the first bit
      top_sh  = csfp_pkg::FIELD_MAX_LEN - len_ff;
      mot_sh  = 3'd7 - start_ff[2:0];
      mot_val = val_ff << top_sh[5:0];
      mot_msk = ~({64{1'b1}} >> len_ff);

      // Intel walks the aligned word from the bottom, Motorola from the top
      if (order_ff == csfp_pkg::ORDER_INTEL) begin
         cur_dat = dat_ff[7:0];
         cur_msk = msk_ff[7:0];
         nxt_dat = dat_ff >> 8;
         nxt_msk = msk_ff >> 8;
      end else begin
         cur_dat = dat_ff[71:64];
         cur_msk = msk_ff[71:64];
         nxt_dat = dat_ff << 8;
         nxt_msk = msk_ff << 8;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dlc_in       = dlc_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      typ_in       = typ_ff;
      raw_in       = raw_ff;
      kind_in      = kind_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      order_in     = order_ff;
      send_in      = send_ff;
      val_in       = val_ff;
      dat_in       = dat_ff;
      msk_in       = msk_ff;
      ptr_in       = ptr_ff;
      wptr_in      = wptr_ff;
      wdat_in      = wdat_ff;
      wmsk_in      = wmsk_ff;
      emit_n_in    = emit_n_ff;
      emit_k_in    = emit_k_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      // merge the byte read last cycle and write it back
      mreq.rd_en   = 1'b0;
      mreq.rd_ptr  = ptr_ff;
      mreq.wr_en   = pend_ff && (wptr_ff < PB);
      mreq.wr_ptr  = wptr_ff;
      mreq.wr_data = (rd_data & ~wmsk_ff) | (wdat_ff & wmsk_ff);

      if (csr_valid && csr_ready) begin
         dlc_in = csr_len_code;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               typ_in   = req_type;
               raw_in   = req_raw_value;
               kind_in  = req_value_kind;
               start_in = req_first_bit;
               // clamp an overlong length to the full word
               len_in   = (req_sig_len > csfp_pkg::FIELD_MAX_LEN) ?
                          csfp_pkg::FIELD_MAX_LEN : req_sig_len;
               order_in = req_endian;
               send_in  = req_send_after;
               state_in = ST_COND;
            end
         end
         ST_COND: begin
            val_in    = cond_value;
            emit_n_in = frame_n;
            emit_k_in = 7'd0;
            if (typ_ff == csfp_pkg::REQ_SEND || len_ff == 7'd0) begin
               // nothing to pack: emit now if asked and the frame is not empty, else drop back to idle
               if ((typ_ff == csfp_pkg::REQ_SEND || send_ff) && frame_n != 7'd0) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            ptr_in = {1'b0, start_ff[8:3]};
            if (order_ff == csfp_pkg::ORDER_INTEL) begin
               dat_in = {8'd0, val_ff} << start_ff[2:0];
               msk_in = {8'd0, len_mask} << start_ff[2:0];
            end else begin
               dat_in = {mot_val, 8'd0} >> mot_sh;
               msk_in = {mot_msk, 8'd0} >> mot_sh;
            end
            state_in = ST_RMW;
         end
         ST_RMW: begin
            // read this byte; its write-back follows next cycle, while any read then goes to a different address
            mreq.rd_en = (ptr_ff < PB);
            pend_in    = 1'b1;
            wptr_in    = ptr_ff;
            wdat_in    = cur_dat;
            wmsk_in    = cur_msk;
            dat_in     = nxt_dat;
            msk_in     = nxt_msk;
            ptr_in     = ptr_ff + 7'd1;
            if (nxt_msk == 72'd0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last write-back happens here, before any emission read
            if (send_ff && emit_n_ff != 7'd0) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            mreq.rd_en  = 1'b1;
            mreq.rd_ptr = emit_k_ff;
            state_in    = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            // hold the read byte until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data;
               rsp_idx_in   = emit_k_ff[5:0];
               rsp_last_in  = (emit_k_ff + 7'd1 == emit_n_ff);
               emit_k_in    = emit_k_ff + 7'd1;
               state_in     = (emit_k_ff + 7'd1 == emit_n_ff) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dlc_ff       <= 4'd8;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dlc_ff       <= dlc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      typ_ff      <= typ_in;
      raw_ff      <= raw_in;
      kind_ff     <= kind_in;
      start_ff    <= start_in;
      len_ff      <= len_in;
      order_ff    <= order_in;
      send_ff     <= send_in;
      val_ff      <= val_in;
      dat_ff      <= dat_in;
      msk_ff      <= msk_in;
      ptr_ff      <= ptr_in;
      wptr_ff     <= wptr_in;
      wdat_ff     <= wdat_in;
      wmsk_ff     <= wmsk_in;
      emit_n_ff   <= emit_n_in;
      emit_k_ff   <= emit_k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // a write-back and a read in the same cycle never hit the same byte
   `CSFP_ASSERT_IMP(a_no_rmw_overlap, pend_ff && mreq.rd_en, wptr_ff != mreq.rd_ptr)
   // every byte visited in the packing loop carries at least one field bit
   `CSFP_ASSERT_IMP(a_rmw_mask_live, state_ff == ST_RMW, cur_msk != 8'd0)
   // emission never runs past the frame length
   `CSFP_ASSERT_IMP(a_emit_in_range, state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD,
                    emit_k_ff < emit_n_ff)
   // the store is not written while the payload streams out
   `CSFP_ASSERT_IMP(a_no_write_on_emit, state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD,
                    !mreq.wr_en)
   // the last byte of a frame returns the sequencer to idle
   `CSFP_ASSERT_NXT(a_last_to_idle, state_ff == ST_EMIT_LD && out_free &&
                    emit_k_ff + 7'd1 == emit_n_ff, state_ff == ST_IDLE && rsp_last_ff)

endmodule
